// ===== sv/ipte_pkg.sv =====
// ----------------------------------------------------------------------------
// ipte_pkg
// Shared types, constants and header check functions for the Ethernet / IPv4
// / TCP payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package ipte_pkg;

    localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;

    localparam logic [3:0] V_DELIVERED    = 4'd0;
    localparam logic [3:0] V_EMPTY        = 4'd1;
    localparam logic [3:0] V_SHORT_IP     = 4'd2;
    localparam logic [3:0] V_NOT_V4       = 4'd3;
    localparam logic [3:0] V_NOT_TCP      = 4'd4;
    localparam logic [3:0] V_BAD_IHL      = 4'd5;
    localparam logic [3:0] V_FRAGMENT     = 4'd6;
    localparam logic [3:0] V_SHORT_TCP    = 4'd7;
    localparam logic [3:0] V_BAD_TOTAL    = 4'd8;
    localparam logic [3:0] V_BAD_TCP_LEN  = 4'd9;
    localparam logic [3:0] V_INCONSISTENT = 4'd10;
    localparam logic [3:0] V_EXCEEDS      = 4'd11;
    localparam logic [3:0] V_PASSED       = 4'd15;

    localparam logic [3:0]  IP_VERSION4   = 4'd4;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [17:0] MIN_HDR_BYTES = 18'd20;
    localparam logic [15:0] REL_PROTOCOL  = 16'd9;
    localparam logic [15:0] REL_VER_IHL   = 16'd0;
    localparam logic [15:0] REL_TOTAL_HI  = 16'd2;
    localparam logic [15:0] REL_TOTAL_LO  = 16'd3;
    localparam logic [15:0] REL_FLAGS_HI  = 16'd6;
    localparam logic [15:0] REL_FLAGS_LO  = 16'd7;
    localparam logic [15:0] TCP_OFF_REL   = 16'd12;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        first_of_record;
        logic        last_of_record;
        logic [15:0] record_length;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_char;
        logic [3:0]  verdict;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [15:0] start;
        logic [15:0] left;
    } t_tcp_chk;

    function automatic logic [3:0] check_ip(
        input logic [15:0] cap,
        input logic [7:0]  vi,
        input logic [7:0]  proto,
        input logic [15:0] total,
        input logic [15:0] fo
    );
        logic [17:0] lk;
        logic [17:0] h;
        logic [17:0] c;
        logic [17:0] tl;
        logic [3:0]  r;
        lk = {2'b00, LINK_HEADER_BYTES};
        h  = {12'd0, vi[3:0], 2'b00};
        c  = {2'b00, cap};
        tl = {2'b00, total};
        if (c < lk + MIN_HDR_BYTES) begin
            r = V_SHORT_IP;
        end else if (vi[7:4] != IP_VERSION4) begin
            r = V_NOT_V4;
        end else if (proto != PROTO_TCP) begin
            r = V_NOT_TCP;
        end else if (h < MIN_HDR_BYTES || lk + h > c) begin
            r = V_BAD_IHL;
        end else if (fo[12:0] != 13'd0 || fo[13]) begin
            r = V_FRAGMENT;
        end else if (lk + h + MIN_HDR_BYTES > c) begin
            r = V_SHORT_TCP;
        end else if (lk + tl > c) begin
            r = V_BAD_TOTAL;
        end else begin
            r = V_PASSED;
        end
        return r;
    endfunction

    function automatic t_tcp_chk check_tcp(
        input logic [15:0] cap,
        input logic [7:0]  vi,
        input logic [15:0] total,
        input logic [3:0]  nib
    );
        logic [17:0] lk;
        logic [17:0] h;
        logic [17:0] t;
        logic [17:0] c;
        logic [17:0] tl;
        logic [17:0] pay;
        logic [17:0] st;
        t_tcp_chk    r;
        lk  = {2'b00, LINK_HEADER_BYTES};
        h   = {12'd0, vi[3:0], 2'b00};
        t   = {12'd0, nib, 2'b00};
        c   = {2'b00, cap};
        tl  = {2'b00, total};
        st  = lk + h + t;
        pay = tl - h - t;
        r.start = st[15:0];
        r.left  = pay[15:0];
        if (t < MIN_HDR_BYTES || st > c) begin
            r.verdict = V_BAD_TCP_LEN;
        end else if (tl < h + t) begin
            r.verdict = V_INCONSISTENT;
        end else if (pay == 18'd0) begin
            r.verdict = V_EMPTY;
        end else if (st + pay > c) begin
            r.verdict = V_EXCEEDS;
        end else begin
            r.verdict = V_DELIVERED;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ipv4_tcp_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// ipv4_tcp_payload_extractor
// Parses captured Ethernet / IPv4 / TCP frames byte by byte and emits the
// printable TCP payload followed by one verdict code per frame.
//
// Input channel: one frame byte per item with first / last markers and the
// capture length on the first byte. Output channel: one result per item,
// either a payload character or the frame verdict.
// A byte is taken at any edge with i_in_valid high and o_in_stall low and is
// parsed in that cycle. Its results go to a four-entry result queue; the
// first reaches the output in the cycle after the byte is taken when the queue
// was empty, otherwise it waits behind older results. A header byte gives no
// result, a payload byte one and a last byte one or two, so one byte per
// cycle is sustained while the receiver takes results, except during runs of
// last bytes that each also carry a payload character.
// o_in_stall rises when the queue holds more than two results: while the
// receiver holds i_out_stall high, or after such a run of two-result bytes.
// Results wait in the queue and none are dropped.
// Reset clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_tcp_payload_extractor (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire ipte_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ipte_pkg::t_out_item o_out_item
);

    logic [15:0] r_pos,   c_pos,   n_pos;
    logic [15:0] r_cap,   c_cap,   n_cap;
    logic [7:0]  r_vi,    c_vi,    n_vi;
    logic [7:0]  r_proto, c_proto, n_proto;
    logic [15:0] r_total, c_total, n_total;
    logic [15:0] r_fo,    c_fo,    n_fo;
    logic [3:0]  r_nib,   c_nib,   n_nib;
    logic [3:0]  r_fv,    c_fv,    n_fv;
    logic        r_known, c_known, n_known;
    logic [15:0] r_start, c_start, n_start;
    logic [15:0] r_left,  c_left,  n_left;

    logic [15:0] w_rel;
    logic        w_in_hdr;
    logic        w_ip_byte;
    logic        w_tcp_byte;
    logic        w_emit;
    logic        w_accept;
    logic        w_full;
    logic [7:0]  w_b;
    logic [7:0]  w_char;
    logic [3:0]  w_ip_v;
    ipte_pkg::t_tcp_chk  w_tcp;
    ipte_pkg::t_out_item w_char_item;
    ipte_pkg::t_out_item w_verd_item;
    ipte_pkg::t_push     w_push;

    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;
    assign w_b        = i_in_item.frame_byte;

    always_comb begin
        if (i_in_item.first_of_record) begin
            c_pos   = 16'd0;
            c_cap   = i_in_item.record_length;
            c_vi    = 8'd0;
            c_proto = 8'd0;
            c_total = 16'd0;
            c_fo    = 16'd0;
            c_nib   = 4'd0;
            c_fv    = 4'd0;
            c_known = 1'b0;
            c_start = 16'd0;
            c_left  = 16'd0;
        end else begin
            c_pos   = r_pos;
            c_cap   = r_cap;
            c_vi    = r_vi;
            c_proto = r_proto;
            c_total = r_total;
            c_fo    = r_fo;
            c_nib   = r_nib;
            c_fv    = r_fv;
            c_known = r_known;
            c_start = r_start;
            c_left  = r_left;
        end

        w_rel    = c_pos - ipte_pkg::LINK_HEADER_BYTES;
        w_in_hdr = !c_known && (c_pos >= ipte_pkg::LINK_HEADER_BYTES);

        n_cap   = c_cap;
        n_vi    = c_vi;
        n_proto = c_proto;
        n_total = c_total;
        n_fo    = c_fo;
        if (w_in_hdr) begin
            priority if (w_rel == ipte_pkg::REL_VER_IHL) begin
                n_vi = w_b;
            end else if (w_rel == ipte_pkg::REL_TOTAL_HI) begin
                n_total = {w_b, c_total[7:0]};
            end else if (w_rel == ipte_pkg::REL_TOTAL_LO) begin
                n_total = {c_total[15:8], w_b};
            end else if (w_rel == ipte_pkg::REL_FLAGS_HI) begin
                n_fo = {w_b, c_fo[7:0]};
            end else if (w_rel == ipte_pkg::REL_FLAGS_LO) begin
                n_fo = {c_fo[15:8], w_b};
            end else if (w_rel == ipte_pkg::REL_PROTOCOL) begin
                n_proto = w_b;
            end else begin
            end
        end

        w_ip_byte  = w_in_hdr && (w_rel == ipte_pkg::REL_PROTOCOL);
        w_tcp_byte = w_in_hdr && (w_rel > ipte_pkg::REL_PROTOCOL)
                     && (w_rel == {10'd0, n_vi[3:0], 2'b00} + ipte_pkg::TCP_OFF_REL);
        n_nib      = w_tcp_byte ? w_b[7:4] : c_nib;

        w_ip_v = ipte_pkg::check_ip(n_cap, n_vi, n_proto, n_total, n_fo);
        w_tcp  = ipte_pkg::check_tcp(n_cap, n_vi, n_total, n_nib);

        n_known = c_known;
        n_fv    = c_fv;
        n_start = c_start;
        n_left  = c_left;

        w_emit = !w_in_hdr && c_known && (c_fv == ipte_pkg::V_DELIVERED)
                 && (c_left != 16'd0) && (c_pos >= c_start);
        if (w_emit) begin
            n_left = c_left - 16'd1;
        end

        if (w_ip_byte && w_ip_v != ipte_pkg::V_PASSED) begin
            n_known = 1'b1;
            n_fv    = w_ip_v;
        end
        if (w_tcp_byte) begin
            n_known = 1'b1;
            n_fv    = w_tcp.verdict;
            if (w_tcp.verdict == ipte_pkg::V_DELIVERED) begin
                n_start = w_tcp.start;
                n_left  = w_tcp.left;
            end
        end
        if (i_in_item.last_of_record && !n_known) begin
            n_known = 1'b1;
            if (w_ip_v != ipte_pkg::V_PASSED) begin
                n_fv = w_ip_v;
            end else begin
                n_fv = w_tcp.verdict;
                if (w_tcp.verdict == ipte_pkg::V_DELIVERED) begin
                    n_start = w_tcp.start;
                    n_left  = w_tcp.left;
                end
            end
        end

        n_pos = (c_pos != ipte_pkg::POS_MAX) ? c_pos + 16'd1 : c_pos;

        if ((w_b >= 8'h20 && w_b <= 8'h7E) || w_b == 8'h0D || w_b == 8'h0A
            || w_b == 8'h09) begin
            w_char = w_b;
        end else begin
            w_char = ipte_pkg::CHAR_DOT;
        end

        w_char_item.result_kind  = ipte_pkg::KIND_CHAR;
        w_char_item.payload_char = w_char;
        w_char_item.verdict      = 4'd0;
        w_char_item.last_of_run  = !i_in_item.last_of_record;

        w_verd_item.result_kind  = ipte_pkg::KIND_VERDICT;
        w_verd_item.payload_char = 8'd0;
        w_verd_item.verdict      = n_fv;
        w_verd_item.last_of_run  = 1'b1;

        w_push.cnt = w_accept ? ({1'b0, w_emit} + {1'b0, i_in_item.last_of_record}) : 2'd0;
        w_push.r0  = w_emit ? w_char_item : w_verd_item;
        w_push.r1  = w_verd_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 16'd0;
            r_cap   <= 16'd0;
            r_vi    <= 8'd0;
            r_proto <= 8'd0;
            r_total <= 16'd0;
            r_fo    <= 16'd0;
            r_nib   <= 4'd0;
            r_fv    <= 4'd0;
            r_known <= 1'b0;
            r_start <= 16'd0;
            r_left  <= 16'd0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_cap   <= n_cap;
            r_vi    <= n_vi;
            r_proto <= n_proto;
            r_total <= n_total;
            r_fo    <= n_fo;
            r_nib   <= n_nib;
            r_fv    <= n_fv;
            r_known <= n_known;
            r_start <= n_start;
            r_left  <= n_left;
        end
    end

    ipte_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // verdict codes stay in range
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind |-> o_out_item.verdict <= ipte_pkg::V_EXCEEDS)
        else $error("verdict code out of range");

    // payload results carry no verdict
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.result_kind |-> o_out_item.verdict == 4'd0)
        else $error("payload result with verdict bits");

    // a last byte always queues a verdict
    a_last_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.last_of_record |-> w_push.cnt != 2'd0 && n_known)
        else $error("last byte without verdict");

    // payload flows only for delivered frames
    a_emit_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_emit |-> r_known && r_fv == ipte_pkg::V_DELIVERED)
        else $error("payload for rejected frame");

endmodule

`default_nettype wire

// ===== sv/ipte_outq.sv =====
// ----------------------------------------------------------------------------
// ipte_outq
// Four-entry result queue; takes up to two results per cycle and hands out
// one per cycle on a valid / stall channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ipte_outq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire ipte_pkg::t_push i_push,
    output logic                o_full,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ipte_pkg::t_out_item o_out_item
);

    ipte_pkg::t_out_item r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_count;
    logic [1:0] n_wp;
    logic [1:0] n_rp;
    logic [2:0] n_count;
    logic       w_pop;

    assign o_out_valid = (r_count != 3'd0);
    assign o_out_item  = r_q[r_rp];
    assign o_full      = (r_count > 3'd2);
    assign w_pop       = o_out_valid && !i_out_stall;

    always_comb begin
        n_wp    = r_wp + i_push.cnt;
        n_rp    = r_rp + {1'b0, w_pop};
        n_count = r_count + {1'b0, i_push.cnt} - {2'b00, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[r_wp + 2'd1] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

// ===== verif/ipv4_tcp_payload_extractor_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_tcp_payload_extractor_tb
// Self-checking bench for the Ethernet / IPv4 / TCP payload extractor. A queue
// of frame bytes (a few directed corner cases, then well-formed and corrupted
// frames with random content plus stray bytes) feeds a clocked driver. Every
// accepted byte runs through a bench-side parser that queues the payload
// characters and verdicts it must cause. A clocked monitor checks each output
// item against the oldest queued result. Both sides idle at random, with one
// calm window and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module ipv4_tcp_payload_extractor_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 1600;
    localparam int HOLD_START    = 800;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    ipte_pkg::t_in_item  in_item = '0;
    logic                out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    ipte_pkg::t_out_item o_out_item;

    ipte_pkg::t_in_item  tx_bytes[$];
    ipte_pkg::t_out_item due_results[$];

    int cycle_cnt = 0;
    int err_count = 0;
    int got_count = 0;
    int hold_cnt = 0;
    logic calm;

    // parser state
    logic [15:0] byte_pos = '0;
    logic [15:0] cap_len = '0;
    logic [7:0]  ver_ihl = '0;
    logic [7:0]  proto = '0;
    logic [15:0] total_len = '0;
    logic [15:0] frag = '0;
    logic [3:0]  doff = '0;
    logic [3:0]  frame_code = '0;
    bit          code_known = 1'b0;
    logic [15:0] pay_start = '0;
    logic [15:0] pay_left = '0;

    ipv4_tcp_payload_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    assign calm = (cycle_cnt >= 1500) && (cycle_cnt < 2100);

    function automatic logic [3:0] judge_ip();
        int lk;
        int h;
        lk = int'(ipte_pkg::LINK_HEADER_BYTES);
        h  = 4 * ver_ihl[3:0];
        if (cap_len < lk + 20) return ipte_pkg::V_SHORT_IP;
        if (ver_ihl[7:4] != ipte_pkg::IP_VERSION4) return ipte_pkg::V_NOT_V4;
        if (proto != ipte_pkg::PROTO_TCP) return ipte_pkg::V_NOT_TCP;
        if (h < 20 || lk + h > cap_len) return ipte_pkg::V_BAD_IHL;
        if (frag[12:0] != 13'd0 || frag[13]) return ipte_pkg::V_FRAGMENT;
        if (lk + h + 20 > cap_len) return ipte_pkg::V_SHORT_TCP;
        if (lk + total_len > cap_len) return ipte_pkg::V_BAD_TOTAL;
        return ipte_pkg::V_PASSED;
    endfunction

    function automatic logic [3:0] judge_tcp();
        int lk;
        int h;
        int t;
        int pay;
        lk = int'(ipte_pkg::LINK_HEADER_BYTES);
        h  = 4 * ver_ihl[3:0];
        t  = 4 * doff;
        if (t < 20 || lk + h + t > cap_len) return ipte_pkg::V_BAD_TCP_LEN;
        if (total_len < h + t) return ipte_pkg::V_INCONSISTENT;
        pay = total_len - h - t;
        if (pay == 0) return ipte_pkg::V_EMPTY;
        if (lk + h + t + pay > cap_len) return ipte_pkg::V_EXCEEDS;
        pay_start = 16'(lk + h + t);
        pay_left  = 16'(pay);
        return ipte_pkg::V_DELIVERED;
    endfunction

    task automatic parse_byte(input ipte_pkg::t_in_item it);
        int                  rel;
        logic [3:0]          v;
        logic [7:0]          c;
        ipte_pkg::t_out_item r;
        if (it.first_of_record) begin
            byte_pos   = '0;
            ver_ihl    = '0;
            proto      = '0;
            total_len  = '0;
            frag       = '0;
            doff       = '0;
            frame_code = '0;
            code_known = 1'b0;
            pay_start  = '0;
            pay_left   = '0;
            cap_len    = it.record_length;
        end
        if (!code_known && byte_pos >= ipte_pkg::LINK_HEADER_BYTES) begin
            rel = int'(byte_pos - ipte_pkg::LINK_HEADER_BYTES);
            case (rel)
                ipte_pkg::REL_VER_IHL:  ver_ihl = it.frame_byte;
                ipte_pkg::REL_TOTAL_HI: total_len[15:8] = it.frame_byte;
                ipte_pkg::REL_TOTAL_LO: total_len[7:0] = it.frame_byte;
                ipte_pkg::REL_FLAGS_HI: frag[15:8] = it.frame_byte;
                ipte_pkg::REL_FLAGS_LO: frag[7:0] = it.frame_byte;
                ipte_pkg::REL_PROTOCOL: proto = it.frame_byte;
                default: ;
            endcase
            if (rel == ipte_pkg::REL_PROTOCOL) begin
                v = judge_ip();
                if (v != ipte_pkg::V_PASSED) begin
                    frame_code = v;
                    code_known = 1'b1;
                end
            end else if (rel > ipte_pkg::REL_PROTOCOL
                         && rel == 4 * ver_ihl[3:0] + ipte_pkg::TCP_OFF_REL) begin
                doff       = it.frame_byte[7:4];
                frame_code = judge_tcp();
                code_known = 1'b1;
            end
        end else if (code_known && frame_code == ipte_pkg::V_DELIVERED && pay_left > 0
                     && byte_pos >= pay_start) begin
            c = it.frame_byte;
            if (!((c >= 8'h20 && c <= 8'h7E) || c == 8'h0D || c == 8'h0A || c == 8'h09))
                c = ipte_pkg::CHAR_DOT;
            r.result_kind  = ipte_pkg::KIND_CHAR;
            r.payload_char = c;
            r.verdict      = '0;
            r.last_of_run  = !it.last_of_record;
            due_results.push_back(r);
            pay_left = pay_left - 16'd1;
        end
        if (it.last_of_record) begin
            if (!code_known) begin
                v = judge_ip();
                if (v == ipte_pkg::V_PASSED) v = judge_tcp();
                frame_code = v;
                code_known = 1'b1;
            end
            r.result_kind  = ipte_pkg::KIND_VERDICT;
            r.payload_char = '0;
            r.verdict      = frame_code;
            r.last_of_run  = 1'b1;
            due_results.push_back(r);
        end
        if (byte_pos < ipte_pkg::POS_MAX) byte_pos = byte_pos + 16'd1;
    endtask

    task automatic add_byte(input logic [7:0] b, input bit first, input bit last,
                            input logic [15:0] len);
        ipte_pkg::t_in_item it;
        it.frame_byte      = b;
        it.first_of_record = first;
        it.last_of_record  = last;
        it.record_length   = len;
        tx_bytes.push_back(it);
    endtask

    task automatic add_frame(input bit broken);
        logic [7:0] fb[$];
        logic [7:0] vi;
        logic [7:0] pr;
        logic [7:0] ch;
        logic [15:0] fl;
        logic [3:0] tcp_nib;
        logic [3:0] lo;
        int ihl;
        int doff_f;
        int pay;
        int total;
        int n;
        int cap;
        int cut;
        int i;
        int sel;
        bit no_last;
        ihl     = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
        doff_f  = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
        pay     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
        total   = 4 * ihl + 4 * doff_f + pay;
        vi      = {ipte_pkg::IP_VERSION4, ihl[3:0]};
        pr      = ipte_pkg::PROTO_TCP;
        fl      = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
        tcp_nib = doff_f[3:0];
        n       = ipte_pkg::LINK_HEADER_BYTES + total
                  + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
        cap     = n;
        cut     = n;
        no_last = 1'b0;
        if (!broken && pay > 0 && $urandom_range(0, 7) == 0)
            cut = $urandom_range(ipte_pkg::LINK_HEADER_BYTES + 4 * ihl + 4 * doff_f, n - 1);
        if (broken) begin
            case ($urandom_range(0, 9))
                0: vi[7:4] = 4'($urandom_range(0, 15));
                1: pr = 8'($urandom_range(0, 255));
                2: vi[3:0] = 4'($urandom_range(0, 15));
                3: fl = 16'($urandom_range(0, 65535));
                4: total = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, total + 10);
                5: tcp_nib = 4'($urandom_range(0, 15));
                6: cap = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, n + 10);
                7: cut = $urandom_range(1, n);
                8: begin
                    cut     = $urandom_range(1, n);
                    no_last = 1'b1;
                end
                default: begin
                    vi      = 8'($urandom_range(0, 255));
                    tcp_nib = 4'($urandom_range(0, 15));
                    total   = $urandom_range(0, 200);
                    cap     = $urandom_range(0, 200);
                end
            endcase
        end
        for (i = 0; i < ipte_pkg::LINK_HEADER_BYTES; i++)
            fb.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < 4 * ihl; i++) begin
            case (i)
                0: fb.push_back(vi);
                2: fb.push_back(total[15:8]);
                3: fb.push_back(total[7:0]);
                6: fb.push_back(fl[15:8]);
                7: fb.push_back(fl[7:0]);
                9: fb.push_back(pr);
                default: fb.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        for (i = 0; i < 4 * doff_f; i++) begin
            lo = 4'($urandom_range(0, 15));
            fb.push_back((i == 12) ? {tcp_nib, lo} : 8'($urandom_range(0, 255)));
        end
        while (fb.size() < n) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                ch = 8'($urandom_range(8'h20, 8'h7E));
            end else if (sel == 5) begin
                case ($urandom_range(0, 2))
                    0: ch = 8'h0D;
                    1: ch = 8'h0A;
                    default: ch = 8'h09;
                endcase
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            fb.push_back(ch);
        end
        for (i = 0; i < cut; i++)
            add_byte(fb[i], i == 0, (i == cut - 1) && !no_last,
                     (i == 0) ? cap[15:0] : 16'($urandom_range(0, 65535)));
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) parse_byte(in_item);
            if (!in_valid || !o_in_stall) begin
                if (tx_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                    in_item  <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (cycle_cnt == HOLD_START) begin
            hold_cnt <= HOLD_CYCLES;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ipte_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got_count++;
                if (due_results.size() == 0) begin
                    note_error($sformatf("unexpected item kind %0b char %02h verdict %0d last %0b",
                        o_out_item.result_kind, o_out_item.payload_char,
                        o_out_item.verdict, o_out_item.last_of_run));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item.result_kind !== want.result_kind
                        || o_out_item.payload_char !== want.payload_char
                        || o_out_item.verdict !== want.verdict
                        || o_out_item.last_of_run !== want.last_of_run)
                        note_error($sformatf(
                            "item %0d exp kind %0b char %02h verdict %0d last %0b, got %0b %02h %0d %0b",
                            got_count, want.result_kind, want.payload_char, want.verdict,
                            want.last_of_run, o_out_item.result_kind, o_out_item.payload_char,
                            o_out_item.verdict, o_out_item.last_of_run));
                end
            end
            out_stall <= (hold_cnt > 0) || (!calm && ($urandom_range(0, 99) < 26));
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int k;
        int pick;
        // one-byte frames at the length extremes, then stray bytes
        add_byte(8'h00, 1'b1, 1'b1, 16'h0000);
        add_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF);
        add_byte(8'hA5, 1'b0, 1'b0, 16'h1234);
        add_byte(8'h5A, 1'b0, 1'b1, 16'hEDCB);
        // frame that ends on the byte right after the version byte
        for (k = 0; k < 16; k++)
            add_byte((k == 14) ? 8'h45 : 8'(k * 17), k == 0, k == 15,
                     (k == 0) ? 16'd34 : 16'd0);
        while (tx_bytes.size() < RANDOM_BYTES + 20) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_frame(1'b0);
            end else if (pick < 92) begin
                add_frame(1'b1);
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                             $urandom_range(0, 1) == 1, 16'($urandom_range(0, 65535)));
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (tx_bytes.size() != 0 || in_valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
